>>> design/dclr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dclr_pkg: shared types and constants for the drive command link receiver
// Holds the protocol modes, acknowledge codes, transaction structs and
// joystick mixing constants.
// ----------------------------------------------------------------------------
package dclr_pkg;

    localparam int BYTE_W   = 8;
    localparam int DUTY_W   = 10;
    localparam int MOTION_W = 2;
    localparam int ANGLE_W  = 15;
    localparam int MODE_W   = 3;
    localparam int CFG_IDX_W = 1;

    // Joystick center and duty ceiling
    localparam logic [BYTE_W-1:0] MID_POINT = 8'd128;
    localparam logic [DUTY_W-1:0] DUTY_MAX  = 10'd1000;
    // offset * 1000 / 128 == (offset * 125) >> 4
    localparam logic [6:0]        AXIS_MUL   = 7'd125;
    localparam int                AXIS_SHIFT = 4;

    localparam logic [BYTE_W-1:0] START_CODE_RESET = 8'hA5;
    localparam logic [BYTE_W-1:0] CHECK_CODE_RESET = 8'hFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_CODE = 1'd1;

    // Acknowledge bytes
    localparam logic [BYTE_W-1:0] REPLY_CHECK_OK   = 8'hFF;
    localparam logic [BYTE_W-1:0] REPLY_CHECK_FAIL = 8'h00;
    localparam logic [BYTE_W-1:0] REPLY_START_AUTO = 8'd4;
    localparam logic [BYTE_W-1:0] REPLY_START_JOY  = 8'd0;
    localparam logic [BYTE_W-1:0] REPLY_IDLE_NONE  = 8'hFF;
    localparam logic [BYTE_W-1:0] REPLY_JOY_X      = 8'd1;
    localparam logic [BYTE_W-1:0] REPLY_JOY_Y      = 8'd2;
    localparam logic [BYTE_W-1:0] REPLY_AUTO_D     = 8'd5;
    localparam logic [BYTE_W-1:0] REPLY_AUTO_A0    = 8'd6;
    localparam logic [BYTE_W-1:0] REPLY_AUTO_A1    = 8'd7;

    // Drive direction codes
    localparam logic [MOTION_W-1:0] MOTION_STOP     = 2'd0;
    localparam logic [MOTION_W-1:0] MOTION_FORWARD  = 2'd1;
    localparam logic [MOTION_W-1:0] MOTION_BACKWARD = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_SELFCHECK = 3'd0,
        MODE_IDLE      = 3'd1,
        MODE_JOY_X     = 3'd2,
        MODE_JOY_Y     = 3'd3,
        MODE_AUTO_D    = 3'd4,
        MODE_AUTO_A0   = 3'd5,
        MODE_AUTO_A1   = 3'd6
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              selected;
        logic              auto_select;
    } rx_item_t;

    typedef struct packed {
        logic                reply_valid;
        logic [BYTE_W-1:0]   reply_byte;
        logic                indicator;
        logic                drive_update;
        logic [MOTION_W-1:0] motion;
        logic [DUTY_W-1:0]   left_duty;
        logic [DUTY_W-1:0]   right_duty;
        logic                auto_valid;
        logic [BYTE_W-1:0]   auto_distance;
        logic [ANGLE_W-1:0]  auto_angle;
        logic                auto_turn_dir;
    } res_item_t;

    typedef struct packed {
        logic [MOTION_W-1:0] motion;
        logic [DUTY_W-1:0]   left_duty;
        logic [DUTY_W-1:0]   right_duty;
    } mix_result_t;

endpackage

>>> design/dclr_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dclr_mix: joystick to differential drive mixer
// Turns an x,y stick pair into a direction and clamped left/right duties.
// ----------------------------------------------------------------------------
module dclr_mix
(
    input  logic [dclr_pkg::BYTE_W-1:0] x,
    input  logic [dclr_pkg::BYTE_W-1:0] y,
    output dclr_pkg::mix_result_t       result
);

    localparam int SUM_W  = dclr_pkg::DUTY_W + 2;
    localparam int PROD_W = dclr_pkg::BYTE_W + 7;

    logic [dclr_pkg::BYTE_W-1:0] speed_off;
    logic [dclr_pkg::BYTE_W-1:0] turn_off;
    logic [PROD_W-1:0]           speed_prod;
    logic [PROD_W-1:0]           turn_prod;
    logic [dclr_pkg::DUTY_W-1:0] speed;
    logic [dclr_pkg::DUTY_W-1:0] turn;
    logic signed [SUM_W-1:0]     left_sum;
    logic signed [SUM_W-1:0]     right_sum;
    logic signed [SUM_W-1:0]     speed_s;
    logic signed [SUM_W-1:0]     turn_s;
    logic signed [SUM_W-1:0]     duty_max_s;

    function automatic logic [dclr_pkg::DUTY_W-1:0] clamp_duty(
        input logic signed [SUM_W-1:0] v,
        input logic signed [SUM_W-1:0] ceiling
    );
        logic [dclr_pkg::DUTY_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > ceiling)
        begin
            r = dclr_pkg::DUTY_MAX;
        end
        else
        begin
            r = v[dclr_pkg::DUTY_W-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        result.motion = dclr_pkg::MOTION_STOP;
        speed_off     = '0;
        if (y > dclr_pkg::MID_POINT)
        begin
            result.motion = dclr_pkg::MOTION_FORWARD;
            speed_off     = y - dclr_pkg::MID_POINT;
        end
        else if (y < dclr_pkg::MID_POINT)
        begin
            result.motion = dclr_pkg::MOTION_BACKWARD;
            speed_off     = dclr_pkg::MID_POINT - y;
        end

        if (x >= dclr_pkg::MID_POINT)
        begin
            turn_off = x - dclr_pkg::MID_POINT;
        end
        else
        begin
            turn_off = dclr_pkg::MID_POINT - x;
        end

        speed_prod = PROD_W'(speed_off) * PROD_W'(dclr_pkg::AXIS_MUL);
        turn_prod  = PROD_W'(turn_off) * PROD_W'(dclr_pkg::AXIS_MUL);
        speed      = speed_prod[dclr_pkg::AXIS_SHIFT +: dclr_pkg::DUTY_W];
        turn       = turn_prod[dclr_pkg::AXIS_SHIFT +: dclr_pkg::DUTY_W];

        speed_s    = signed'({2'b00, speed});
        turn_s     = signed'({2'b00, turn});
        duty_max_s = signed'({2'b00, dclr_pkg::DUTY_MAX});

        // Stick right speeds up the left wheel
        if (x >= dclr_pkg::MID_POINT)
        begin
            left_sum  = speed_s + turn_s;
            right_sum = speed_s - turn_s;
        end
        else
        begin
            left_sum  = speed_s - turn_s;
            right_sum = speed_s + turn_s;
        end

        result.left_duty  = clamp_duty(left_sum, duty_max_s);
        result.right_duty = clamp_duty(right_sum, duty_max_s);
    end

endmodule

>>> design/drive_command_link_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_command_link_receiver: link command protocol and drive command decode
// Runs the self-check / idle / joystick / autonomous byte protocol and
// produces one result transaction for every received byte.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel (rx_valid / rx_stall / rx_item) carries one link byte with
//   its chip-select and auto-mode pin levels per transaction. res channel
//   (res_valid / res_stall / res_item) returns exactly one result per byte:
//   reply byte, indicator level, and drive or autonomous command when a
//   sequence completes.
//   A taken byte passes through the input register, then protocol decode
//   and joystick mixing into the result register, which drives res_valid.
//   Throughput: one transaction per cycle while res is not stalled; protocol
//   decode and mixer are combinational, so nothing limits back-to-back bytes.
//   When the receiver stalls res, the result register holds and the input
//   register fills; rx_stall rises only once both stages are occupied.
//   cfg_we writes start_code (index 0) or check_code (index 1);
//   write only while no transaction is in flight.
//   Reset clears both pipeline valids, puts the protocol in self-check,
//   clears the held bytes and the indicator, and restores the codes.
// ----------------------------------------------------------------------------
module drive_command_link_receiver
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rx_valid,
    output logic                             rx_stall,
    input  dclr_pkg::rx_item_t               rx_item,
    output logic                             res_valid,
    input  logic                             res_stall,
    output dclr_pkg::res_item_t              res_item,
    input  logic                             cfg_we,
    input  logic [dclr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dclr_pkg::BYTE_W-1:0]      cfg_data
);

    // Pipeline control
    logic                     in_valid_reg;
    dclr_pkg::rx_item_t       in_item_reg;
    logic                     out_valid_reg;
    dclr_pkg::res_item_t      out_item_reg;
    logic                     advance;
    logic                     rx_take;

    // Protocol state
    dclr_pkg::mode_t          mode_reg;
    dclr_pkg::mode_t          mode_next;
    logic [dclr_pkg::BYTE_W-1:0] x_hold_reg;
    logic [dclr_pkg::BYTE_W-1:0] x_hold_next;
    logic [dclr_pkg::BYTE_W-1:0] distance_hold_reg;
    logic [dclr_pkg::BYTE_W-1:0] distance_hold_next;
    logic [dclr_pkg::BYTE_W-1:0] angle_high_hold_reg;
    logic [dclr_pkg::BYTE_W-1:0] angle_high_hold_next;
    logic                     indicator_reg;
    logic                     indicator_next;
    logic [dclr_pkg::BYTE_W-1:0] start_code_reg;
    logic [dclr_pkg::BYTE_W-1:0] check_code_reg;

    dclr_pkg::res_item_t      result_next;
    dclr_pkg::mix_result_t    mix_out;

    // Result register moves when empty or when its transaction is taken
    assign advance  = !out_valid_reg || !res_stall;
    assign rx_stall = in_valid_reg && !advance;
    assign rx_take  = rx_valid && !rx_stall;

    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

    dclr_mix u_mix
    (
        .x      (x_hold_reg),
        .y      (in_item_reg.rx_byte),
        .result (mix_out)
    );

    // Protocol decode for the byte held in the input register
    always_comb
    begin
        mode_next            = mode_reg;
        x_hold_next          = x_hold_reg;
        distance_hold_next   = distance_hold_reg;
        angle_high_hold_next = angle_high_hold_reg;
        indicator_next       = indicator_reg;
        result_next          = '0;

        if (in_item_reg.selected)
        begin
            result_next.reply_valid = 1'b1;
            case (mode_reg)
                dclr_pkg::MODE_SELFCHECK:
                begin
                    if (in_item_reg.rx_byte == check_code_reg)
                    begin
                        result_next.reply_byte = dclr_pkg::REPLY_CHECK_OK;
                        indicator_next         = 1'b0;
                        mode_next              = dclr_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        result_next.reply_byte = dclr_pkg::REPLY_CHECK_FAIL;
                        indicator_next         = 1'b1;
                    end
                end
                dclr_pkg::MODE_IDLE:
                begin
                    if (in_item_reg.rx_byte == start_code_reg)
                    begin
                        indicator_next = 1'b0;
                        if (in_item_reg.auto_select)
                        begin
                            result_next.reply_byte = dclr_pkg::REPLY_START_AUTO;
                            mode_next              = dclr_pkg::MODE_AUTO_D;
                        end
                        else
                        begin
                            result_next.reply_byte = dclr_pkg::REPLY_START_JOY;
                            mode_next              = dclr_pkg::MODE_JOY_X;
                        end
                    end
                    else
                    begin
                        result_next.reply_byte = dclr_pkg::REPLY_IDLE_NONE;
                        indicator_next         = 1'b1;
                    end
                end
                dclr_pkg::MODE_JOY_X:
                begin
                    indicator_next         = 1'b1;
                    x_hold_next            = in_item_reg.rx_byte;
                    result_next.reply_byte = dclr_pkg::REPLY_JOY_X;
                    mode_next              = dclr_pkg::MODE_JOY_Y;
                end
                dclr_pkg::MODE_JOY_Y:
                begin
                    indicator_next           = 1'b0;
                    result_next.reply_byte   = dclr_pkg::REPLY_JOY_Y;
                    result_next.drive_update = 1'b1;
                    result_next.motion       = mix_out.motion;
                    result_next.left_duty    = mix_out.left_duty;
                    result_next.right_duty   = mix_out.right_duty;
                    mode_next                = dclr_pkg::MODE_IDLE;
                end
                dclr_pkg::MODE_AUTO_D:
                begin
                    indicator_next         = 1'b1;
                    distance_hold_next     = in_item_reg.rx_byte;
                    result_next.reply_byte = dclr_pkg::REPLY_AUTO_D;
                    mode_next              = dclr_pkg::MODE_AUTO_A0;
                end
                dclr_pkg::MODE_AUTO_A0:
                begin
                    // Indicator stays on from the distance byte
                    angle_high_hold_next   = in_item_reg.rx_byte;
                    result_next.reply_byte = dclr_pkg::REPLY_AUTO_A0;
                    mode_next              = dclr_pkg::MODE_AUTO_A1;
                end
                dclr_pkg::MODE_AUTO_A1:
                begin
                    indicator_next            = 1'b0;
                    result_next.reply_byte    = dclr_pkg::REPLY_AUTO_A1;
                    result_next.auto_valid    = 1'b1;
                    result_next.auto_distance = distance_hold_reg;
                    result_next.auto_angle    = {angle_high_hold_reg,
                                                 in_item_reg.rx_byte[dclr_pkg::BYTE_W-1:1]};
                    result_next.auto_turn_dir = in_item_reg.rx_byte[0];
                    mode_next                 = dclr_pkg::MODE_IDLE;
                end
                default:
                begin
                    // Unused mode code: drop the reply and restart self-check
                    result_next.reply_valid = 1'b0;
                    mode_next               = dclr_pkg::MODE_SELFCHECK;
                end
            endcase
        end

        result_next.indicator = indicator_next;
    end

    // Pipeline valids and protocol state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            mode_reg            <= dclr_pkg::MODE_SELFCHECK;
            x_hold_reg          <= '0;
            distance_hold_reg   <= '0;
            angle_high_hold_reg <= '0;
            indicator_reg       <= 1'b0;
            start_code_reg      <= dclr_pkg::START_CODE_RESET;
            check_code_reg      <= dclr_pkg::CHECK_CODE_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dclr_pkg::CFG_START_CODE: start_code_reg <= cfg_data;
                    dclr_pkg::CFG_CHECK_CODE: check_code_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (rx_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    mode_reg            <= mode_next;
                    x_hold_reg          <= x_hold_next;
                    distance_hold_reg   <= distance_hold_next;
                    angle_high_hold_reg <= angle_high_hold_next;
                    indicator_reg       <= indicator_next;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            in_item_reg <= rx_item;
        end
        if (advance && in_valid_reg)
        begin
            out_item_reg <= result_next;
        end
    end

    // A completed joystick pair always carries the second joystick acknowledge
    a_drive_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.drive_update) |->
        (res_item.reply_valid && res_item.reply_byte == dclr_pkg::REPLY_JOY_Y))
        else $error("drive update without joystick y acknowledge");

    // Drive and autonomous commands never complete on the same byte
    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_item.drive_update && res_item.auto_valid))
        else $error("drive and autonomous command in one result");

    // Duties stay within the clamp range
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.left_duty <= dclr_pkg::DUTY_MAX &&
                       res_item.right_duty <= dclr_pkg::DUTY_MAX))
        else $error("duty out of range");

    // A byte taken while both stages are full would be lost
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && res_stall) |=> in_valid_reg)
        else $error("input register dropped a transaction under stall");

endmodule

>>> bench/drive_command_link_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_command_link_receiver_tb: self-checking bench for the link receiver
// Walks a short table of directed link bytes, then long runs of random
// joystick and autonomous command sequences under several start/check code
// settings. Both channels idle and stall at random, and the result channel
// is held off for a long stretch once per phase. Every result transaction
// is compared field by field against a typed-in expectation or a bench-side predictor.
// ----------------------------------------------------------------------------
module drive_command_link_receiver_tb;

    // No acceptance on either channel for as long as this limit while work
    // is outstanding ends the run. Longest legal pause is the hold-off
    // followed by the rest of a random stall.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int NUM_PHASES = 5;
    localparam int DIR_ROWS = 23;

    // One stimulus transaction plus an optional typed-in expected result
    typedef struct packed {
        dclr_pkg::rx_item_t  item;
        logic                typed;
        dclr_pkg::res_item_t exp;
    } link_txn_t;

    // Directed table row: byte, pins, and the reply fields when typed in
    typedef struct packed {
        logic [dclr_pkg::BYTE_W-1:0] rx;
        logic                        sel;
        logic                        auto_pin;
        logic                        typed;
        logic                        rv;
        logic [dclr_pkg::BYTE_W-1:0] rb;
        logic                        ind;
    } dir_row_t;

    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // self-check: ignored byte, mismatch, then match
        '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h12, 1'b1, 1'b0, 1'b1, 1'b1, dclr_pkg::REPLY_CHECK_FAIL, 1'b1},
        '{dclr_pkg::CHECK_CODE_RESET, 1'b1, 1'b1, 1'b1, 1'b1, dclr_pkg::REPLY_CHECK_OK, 1'b0},
        // idle: no start code, then an ignored byte keeps the indicator on
        '{8'h00, 1'b1, 1'b0, 1'b1, 1'b1, dclr_pkg::REPLY_IDLE_NONE, 1'b1},
        '{8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1},
        // joystick x full right, y full back: left saturates
        '{dclr_pkg::START_CODE_RESET, 1'b1, 1'b0, 1'b1, 1'b1, dclr_pkg::REPLY_START_JOY, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, dclr_pkg::REPLY_JOY_X, 1'b1},
        '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        // joystick x full left, y full forward: left goes negative, clamps
        '{dclr_pkg::START_CODE_RESET, 1'b1, 1'b0, 1'b1, 1'b1, dclr_pkg::REPLY_START_JOY, 1'b0},
        '{8'h00, 1'b1, 1'b0, 1'b1, 1'b1, dclr_pkg::REPLY_JOY_X, 1'b1},
        '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
        // joystick centered: stop
        '{dclr_pkg::START_CODE_RESET, 1'b1, 1'b0, 1'b1, 1'b1, dclr_pkg::REPLY_START_JOY, 1'b0},
        '{8'h80, 1'b1, 1'b0, 1'b1, 1'b1, dclr_pkg::REPLY_JOY_X, 1'b1},
        '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        // autonomous all ones, ignored byte mid-sequence, angle high keeps
        // the indicator from the distance byte
        '{dclr_pkg::START_CODE_RESET, 1'b1, 1'b1, 1'b1, 1'b1, dclr_pkg::REPLY_START_AUTO, 1'b0},
        '{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, dclr_pkg::REPLY_AUTO_D, 1'b1},
        '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1},
        '{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, dclr_pkg::REPLY_AUTO_A0, 1'b1},
        '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
        // autonomous all zeros
        '{dclr_pkg::START_CODE_RESET, 1'b1, 1'b1, 1'b1, 1'b1, dclr_pkg::REPLY_START_AUTO, 1'b0},
        '{8'h00, 1'b1, 1'b0, 1'b1, 1'b1, dclr_pkg::REPLY_AUTO_D, 1'b1},
        '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1, dclr_pkg::REPLY_AUTO_A0, 1'b1},
        '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}
    };

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            rx_valid = 1'b0;
    logic                            rx_stall;
    dclr_pkg::rx_item_t              rx_item = '0;
    logic                            res_valid;
    logic                            res_stall = 1'b0;
    dclr_pkg::res_item_t             res_item;
    logic                            cfg_we = 1'b0;
    logic [dclr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dclr_pkg::BYTE_W-1:0]     cfg_data = '0;

    // Transaction on the rx port, with its typed-in expectation if any
    link_txn_t             tx_cur = '0;

    // Queued by the main sequence, read in order by the sender
    link_txn_t             byte_queue[$];
    int                    send_idx = 0;
    dclr_pkg::res_item_t   pending_replies[$];
    int                    queued_count = 0;
    int                    done_count = 0;
    int                    errors = 0;

    // Predictor copy of the protocol state and the code registers
    dclr_pkg::mode_t                 pm_mode = dclr_pkg::MODE_SELFCHECK;
    logic [dclr_pkg::BYTE_W-1:0]     pm_x = '0;
    logic [dclr_pkg::BYTE_W-1:0]     pm_dist = '0;
    logic [dclr_pkg::BYTE_W-1:0]     pm_ang_hi = '0;
    logic                            pm_ind = 1'b0;
    logic [dclr_pkg::BYTE_W-1:0]     start_code_q = dclr_pkg::START_CODE_RESET;
    logic [dclr_pkg::BYTE_W-1:0]     check_code_q = dclr_pkg::CHECK_CODE_RESET;

    // Sender and receiver pacing
    int                    gap_left = 0;
    int                    burst_left = 0;
    int                    stall_left = 0;
    int                    free_left = 0;
    int                    hold_left = 0;
    int                    pressure_asks = 0;
    int                    pressure_done = 0;
    int                    idle_cycles = 0;

    drive_command_link_receiver dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_item   (rx_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Offset from center scaled to thousandths of full deflection
    function automatic int axis_scale(int offset);
        return (offset * int'(dclr_pkg::DUTY_MAX)) / int'(dclr_pkg::MID_POINT);
    endfunction

    function automatic logic [dclr_pkg::DUTY_W-1:0] clamp_duty(int v);
        if (v > int'(dclr_pkg::DUTY_MAX))
            return dclr_pkg::DUTY_MAX;
        if (v < 0)
            return '0;
        return v[dclr_pkg::DUTY_W-1:0];
    endfunction

    // Arcade mix of a joystick pair into direction and left/right duty
    function automatic dclr_pkg::mix_result_t joy_mix(logic [dclr_pkg::BYTE_W-1:0] x,
                                                      logic [dclr_pkg::BYTE_W-1:0] y);
        dclr_pkg::mix_result_t m;
        int          speed;
        int          turn;
        int          left;
        int          right;
        speed = 0;
        m.motion = dclr_pkg::MOTION_STOP;
        if (y > dclr_pkg::MID_POINT)
        begin
            m.motion = dclr_pkg::MOTION_FORWARD;
            speed = axis_scale(int'(y) - int'(dclr_pkg::MID_POINT));
        end
        else if (y < dclr_pkg::MID_POINT)
        begin
            m.motion = dclr_pkg::MOTION_BACKWARD;
            speed = axis_scale(int'(dclr_pkg::MID_POINT) - int'(y));
        end
        if (x >= dclr_pkg::MID_POINT)
        begin
            turn = axis_scale(int'(x) - int'(dclr_pkg::MID_POINT));
            left = speed + turn;
            right = speed - turn;
        end
        else
        begin
            turn = axis_scale(int'(dclr_pkg::MID_POINT) - int'(x));
            left = speed - turn;
            right = speed + turn;
        end
        m.left_duty = clamp_duty(left);
        m.right_duty = clamp_duty(right);
        return m;
    endfunction

    // Advance the protocol by one byte and return the result it causes
    function automatic dclr_pkg::res_item_t predict_reply(dclr_pkg::rx_item_t it);
        dclr_pkg::res_item_t   r;
        dclr_pkg::mix_result_t m;
        r = '0;
        if (!it.selected)
        begin
            // Deselected: nothing moves, indicator shows the held level
            r.indicator = pm_ind;
            return r;
        end
        r.reply_valid = 1'b1;
        case (pm_mode)
            dclr_pkg::MODE_SELFCHECK:
            begin
                if (it.rx_byte == check_code_q)
                begin
                    r.reply_byte = dclr_pkg::REPLY_CHECK_OK;
                    pm_ind = 1'b0;
                    pm_mode = dclr_pkg::MODE_IDLE;
                end
                else
                begin
                    r.reply_byte = dclr_pkg::REPLY_CHECK_FAIL;
                    pm_ind = 1'b1;
                end
            end
            dclr_pkg::MODE_IDLE:
            begin
                if (it.rx_byte == start_code_q)
                begin
                    r.reply_byte = it.auto_select ? dclr_pkg::REPLY_START_AUTO
                                                  : dclr_pkg::REPLY_START_JOY;
                    pm_ind = 1'b0;
                    pm_mode = it.auto_select ? dclr_pkg::MODE_AUTO_D : dclr_pkg::MODE_JOY_X;
                end
                else
                begin
                    r.reply_byte = dclr_pkg::REPLY_IDLE_NONE;
                    pm_ind = 1'b1;
                end
            end
            dclr_pkg::MODE_JOY_X:
            begin
                pm_ind = 1'b1;
                pm_x = it.rx_byte;
                r.reply_byte = dclr_pkg::REPLY_JOY_X;
                pm_mode = dclr_pkg::MODE_JOY_Y;
            end
            dclr_pkg::MODE_JOY_Y:
            begin
                pm_ind = 1'b0;
                m = joy_mix(pm_x, it.rx_byte);
                r.drive_update = 1'b1;
                r.motion = m.motion;
                r.left_duty = m.left_duty;
                r.right_duty = m.right_duty;
                r.reply_byte = dclr_pkg::REPLY_JOY_Y;
                pm_mode = dclr_pkg::MODE_IDLE;
            end
            dclr_pkg::MODE_AUTO_D:
            begin
                pm_ind = 1'b1;
                pm_dist = it.rx_byte;
                r.reply_byte = dclr_pkg::REPLY_AUTO_D;
                pm_mode = dclr_pkg::MODE_AUTO_A0;
            end
            dclr_pkg::MODE_AUTO_A0:
            begin
                // Indicator stays as the distance byte left it
                pm_ang_hi = it.rx_byte;
                r.reply_byte = dclr_pkg::REPLY_AUTO_A0;
                pm_mode = dclr_pkg::MODE_AUTO_A1;
            end
            dclr_pkg::MODE_AUTO_A1:
            begin
                pm_ind = 1'b0;
                r.auto_valid = 1'b1;
                r.auto_distance = pm_dist;
                r.auto_angle = {pm_ang_hi, it.rx_byte[dclr_pkg::BYTE_W-1:1]};
                r.auto_turn_dir = it.rx_byte[0];
                r.reply_byte = dclr_pkg::REPLY_AUTO_A1;
                pm_mode = dclr_pkg::MODE_IDLE;
            end
            default:
            begin
                // Unused mode code: no reply, fall back to self-check
                r.reply_valid = 1'b0;
                pm_mode = dclr_pkg::MODE_SELFCHECK;
            end
        endcase
        r.indicator = pm_ind;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic cmp_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    task automatic check_reply(dclr_pkg::res_item_t e, dclr_pkg::res_item_t a);
        cmp_field("reply_valid", 32'(e.reply_valid), 32'(a.reply_valid));
        cmp_field("reply_byte", 32'(e.reply_byte), 32'(a.reply_byte));
        cmp_field("indicator", 32'(e.indicator), 32'(a.indicator));
        cmp_field("drive_update", 32'(e.drive_update), 32'(a.drive_update));
        cmp_field("motion", 32'(e.motion), 32'(a.motion));
        cmp_field("left_duty", 32'(e.left_duty), 32'(a.left_duty));
        cmp_field("right_duty", 32'(e.right_duty), 32'(a.right_duty));
        cmp_field("auto_valid", 32'(e.auto_valid), 32'(a.auto_valid));
        cmp_field("auto_distance", 32'(e.auto_distance), 32'(a.auto_distance));
        cmp_field("auto_angle", 32'(e.auto_angle), 32'(a.auto_angle));
        cmp_field("auto_turn_dir", 32'(e.auto_turn_dir), 32'(a.auto_turn_dir));
    endtask

    // Sample both channels at the edge: results first, then new bytes.
    // A byte accepted at this edge cannot have its result at the same edge.
    always @(posedge clk)
    begin
        dclr_pkg::res_item_t e;
        dclr_pkg::res_item_t p;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                done_count++;
                if (pending_replies.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected: expected none, got %h",
                             $time, res_item);
                end
                else
                begin
                    e = pending_replies.pop_front();
                    check_reply(e, res_item);
                end
            end
            if (rx_valid && !rx_stall)
            begin
                // Always run the predictor so its state tracks the block;
                // a typed-in row overrides what it would expect.
                p = predict_reply(rx_item);
                pending_replies.push_back(tx_cur.typed ? tx_cur.exp : p);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: presents queued bytes, holds each until accepted, and
    // inserts gaps of random length between transactions.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        int r;
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
        end
        else if (!rx_valid || !rx_stall)
        begin
            if (gap_left > 0)
            begin
                rx_valid <= 1'b0;
                gap_left--;
            end
            else if (send_idx < byte_queue.size())
            begin
                tx_cur <= byte_queue[send_idx];
                rx_item <= byte_queue[send_idx].item;
                rx_valid <= 1'b1;
                send_idx++;
                // Pick the gap after this transaction: bursts with no gap,
                // mostly short gaps, a few long ones
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        burst_left = $urandom_range(5, 40);
                    else if (r < 85)
                        gap_left = $urandom_range(1, 3);
                    else
                        gap_left = $urandom_range(8, 30);
                end
            end
            else
            begin
                rx_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, free-running stretches, and a long
    // hold-off on request so the block fills and stalls its input.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        int r;
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else if (pressure_done != pressure_asks)
        begin
            pressure_done = pressure_asks;
            hold_left = HOLD_OFF_CYCLES;
            res_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else if (free_left > 0)
        begin
            res_stall <= 1'b0;
            free_left--;
        end
        else
        begin
            r = $urandom_range(0, 99);
            res_stall <= 1'b0;
            if (r < 70)
                free_left = $urandom_range(1, 30);
            else if (r < 95)
                stall_left = $urandom_range(1, 3);
            else
                stall_left = $urandom_range(10, 40);
        end
    end

    // Watchdog: count cycles with work outstanding and no acceptance
    always @(posedge clk)
    begin
        if ((rx_valid && !rx_stall) || (res_valid && !res_stall) ||
            queued_count == done_count)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding", $time,
                     queued_count - done_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_txn(dclr_pkg::rx_item_t it, logic typed, dclr_pkg::res_item_t exp);
        link_txn_t t;
        t.item = it;
        t.typed = typed;
        t.exp = exp;
        queued_count++;
        byte_queue.push_back(t);
    endtask

    // Data byte with the joystick center and the extremes weighted in
    function automatic logic [dclr_pkg::BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 8'h00;
        if (r < 10)
            return 8'hFF;
        if (r < 15)
            return dclr_pkg::MID_POINT;
        if (r < 18)
            return dclr_pkg::MID_POINT - 8'd1;
        if (r < 21)
            return dclr_pkg::MID_POINT + 8'd1;
        return 8'($urandom_range(0, 255));
    endfunction

    // Queue one selected byte, sometimes preceded by a deselected one
    // that the block must ignore
    task automatic offer_byte(logic [dclr_pkg::BYTE_W-1:0] b, logic auto_pin, ref int count);
        dclr_pkg::rx_item_t it;
        if ($urandom_range(0, 99) < 8)
        begin
            it.rx_byte = 8'($urandom_range(0, 255));
            it.selected = 1'b0;
            it.auto_select = 1'($urandom_range(0, 1));
            push_txn(it, 1'b0, '0);
        end
        it.rx_byte = b;
        it.selected = 1'b1;
        it.auto_select = auto_pin;
        push_txn(it, 1'b0, '0);
        count++;
    endtask

    // Mostly well-formed command sequences with random content, the rest
    // noise bytes in idle that never match the start code
    task automatic queue_random_phase(int n_items);
        int                          count;
        int                          r;
        logic [dclr_pkg::BYTE_W-1:0] b;
        count = 0;
        while (count < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                offer_byte(start_code_q, 1'b0, count);
                offer_byte(pick_byte(), 1'($urandom_range(0, 1)), count);
                offer_byte(pick_byte(), 1'($urandom_range(0, 1)), count);
            end
            else if (r < 85)
            begin
                offer_byte(start_code_q, 1'b1, count);
                offer_byte(pick_byte(), 1'($urandom_range(0, 1)), count);
                offer_byte(pick_byte(), 1'($urandom_range(0, 1)), count);
                offer_byte(pick_byte(), 1'($urandom_range(0, 1)), count);
            end
            else
            begin
                b = 8'($urandom_range(0, 255));
                if (b == start_code_q)
                    b = b ^ 8'h01;
                offer_byte(b, 1'($urandom_range(0, 1)), count);
            end
        end
    endtask

    // Hold until every queued transaction has its result, then let the
    // pipeline settle
    task automatic wait_drained();
        while (queued_count != done_count)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [dclr_pkg::CFG_IDX_W-1:0] idx,
                             logic [dclr_pkg::BYTE_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == dclr_pkg::CFG_START_CODE)
            start_code_q = data;
        else
            check_code_q = data;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        dclr_pkg::rx_item_t          it;
        dclr_pkg::res_item_t         e;
        logic [dclr_pkg::BYTE_W-1:0] start_v;
        logic [dclr_pkg::BYTE_W-1:0] check_v;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset codes
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            it.rx_byte = DIR_TAB[i].rx;
            it.selected = DIR_TAB[i].sel;
            it.auto_select = DIR_TAB[i].auto_pin;
            e = '0;
            e.reply_valid = DIR_TAB[i].rv;
            e.reply_byte = DIR_TAB[i].rb;
            e.indicator = DIR_TAB[i].ind;
            push_txn(it, DIR_TAB[i].typed, e);
        end
        wait_drained();

        // Random phases, each under its own pair of codes; the first two
        // take the extremes. Check code only matters in self-check, which
        // is behind us, but write it anyway.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    start_v = 8'h00;
                    check_v = 8'hFF;
                end
                1:
                begin
                    start_v = 8'hFF;
                    check_v = 8'h00;
                end
                default:
                begin
                    start_v = 8'($urandom_range(0, 255));
                    check_v = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(dclr_pkg::CFG_START_CODE, start_v);
            write_reg(dclr_pkg::CFG_CHECK_CODE, check_v);
            pressure_asks++;
            queue_random_phase(ITEMS_PER_PHASE);
            wait_drained();
        end

        if (errors == 0 && pending_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
